// ----- rtl/wvm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator of the voice mixer.
package wvm_pkg;

	// Table and block geometry (powers of two), phase format
	localparam int TABLE_LOG2 = 10;
	localparam int TABLE_LEN  = 1 << TABLE_LOG2;
	localparam int BLOCK_LOG2 = 8;
	localparam int BLOCK_LEN  = 1 << BLOCK_LOG2;
	localparam int FRAC_BITS  = 16;
	localparam int PHASE_W    = TABLE_LOG2 + FRAC_BITS;
	// low bits of step * block count that survive the shift by the block length
	localparam int RE_W       = PHASE_W - BLOCK_LOG2;

	localparam int DEF_MAX_VOICES = 16;
	localparam int QUEUE_DEPTH    = 4;

	// Field and register widths
	localparam int KIND_W     = 2;
	localparam int VOICE_W    = 4;
	localparam int INC_W      = 26;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int ACTIVE_W   = 5;
	localparam int COUNT_W    = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Final scaling: Q1.31 sum times Q1.15 gain, back to Q1.15 sample
	localparam int OUT_SHIFT = 31;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam int POS_LIMIT = 32767;
	localparam int NEG_LIMIT = 32768;

	// Request kinds on the input channel
	localparam logic [KIND_W-1:0] KIND_PITCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ON    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 2'd2;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;
	localparam logic [GAIN_W-1:0]   MIX_RST    = 16'd3891;
	localparam logic [GAIN_W-1:0]   MASTER_RST = 16'd32768;

	typedef enum logic [1:0] {
		OP_PITCH,
		OP_ON,
		OP_TICK
	} op_t;

	// Classified request, front to back
	typedef struct packed {
		op_t                op;
		logic [VOICE_W-1:0] voice;
		logic [INC_W-1:0]   increment;
		logic               on_flag;
	} cmd_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0] active_voices;
		logic [GAIN_W-1:0]   mix_gain;
		logic [GAIN_W-1:0]   master_gain;
	} cfg_t;

	typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_LEN];

	// One sine period, Q1.15; quarter-wave Taylor series in Q30 up to x^11
	function automatic sine_rom_t build_sine_rom();
		localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
		localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
		sine_rom_t rom;
		logic [63:0] p;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [1:0]  quad;
		for (int i = 0; i < TABLE_LEN; i++) begin
			p    = (64'(i) << 32) / TABLE_LEN;
			quad = p[31:30];
			f    = p & (Q30_ONE - 64'd1);
			if (quad[0]) begin
				f = Q30_ONE - f;
			end
			x  = (f * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 64'd110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[i] = quad[1] ? SAMPLE_W'(64'd0 - v) : SAMPLE_W'(v);
		end
		return rom;
	endfunction

endpackage

// ----- rtl/wvm_ifs.sv -----
`timescale 1ns / 1ps
// Request channel into the mixer
interface wvm_in_if import wvm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VOICE_W-1:0] voice;
	logic [INC_W-1:0]   increment;
	logic               on_flag;

	modport source (output valid, kind, voice, increment, on_flag, input ready);
	modport sink (input valid, kind, voice, increment, on_flag, output ready);
endinterface

// Sample channel out of the mixer
interface wvm_out_if import wvm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       clipped;

	modport source (output valid, sample, clipped, input ready);
	modport sink (input valid, sample, clipped, output ready);
endinterface

// ----- rtl/wavetable_voice_mixer.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Carries
// in_ch     in         kind, voice, increment, on_flag (pitch, on flag, tick)
// out_ch    out        sample, clipped (one per tick)
// cfg_*     in         write of active_voices, mix_gain, master_gain
//
// A pitch or on-flag request is written to the voice state as the back end
// pops it; the front takes one request per cycle while the four-entry queue
// has room. A tick walks the n active voices, one voice per cycle, through the
// shared lookup/gain pipe, then does the two-part master gain multiply; with
// no voice active it goes straight to the multiply.
// Reset clears all voice state and counters at once and loads the register
// defaults. A stalled output holds the next tick in its final state.
module wavetable_voice_mixer import wvm_pkg::*; #(
	parameter int MAX_VOICES = DEF_MAX_VOICES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wvm_in_if.sink                in_ch,
	wvm_out_if.source             out_ch
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t push_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_voices <= ACTIVE_RST;
			cfg_q.mix_gain      <= MIX_RST;
			cfg_q.master_gain   <= MASTER_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ACTIVE: cfg_q.active_voices <= cfg_wdata[ACTIVE_W-1:0];
				CFG_MIX:    cfg_q.mix_gain      <= cfg_wdata[GAIN_W-1:0];
				CFG_MASTER: cfg_q.master_gain   <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	wvm_front #(
		.MAX_VOICES(MAX_VOICES)
	) u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (push_cmd)
	);

	wvm_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (pop_cmd)
	);

	wvm_back #(
		.MAX_VOICES(MAX_VOICES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_cmd   (pop_cmd),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ----- rtl/wvm_front.sv -----
`timescale 1ns / 1ps
// Front end: takes requests while the queue has room, drops the ones that
// change nothing, and turns the rest into queue entries.
module wvm_front import wvm_pkg::*; #(
	parameter int MAX_VOICES = DEF_MAX_VOICES
) (
	wvm_in_if.sink   in_ch,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd
);

	logic accept;
	logic voice_ok;
	logic keep;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign voice_ok    = 32'(in_ch.voice) < MAX_VOICES;

	// classify: zero increment, bad voice and unused kind are dropped
	always_comb begin
		keep            = 1'b0;
		q_cmd.op        = OP_TICK;
		q_cmd.voice     = in_ch.voice;
		q_cmd.increment = in_ch.increment;
		q_cmd.on_flag   = in_ch.on_flag;
		case (in_ch.kind)
			KIND_PITCH: begin
				keep     = voice_ok && (in_ch.increment != '0);
				q_cmd.op = OP_PITCH;
			end
			KIND_ON: begin
				keep     = voice_ok;
				q_cmd.op = OP_ON;
			end
			KIND_TICK: begin
				keep     = 1'b1;
				q_cmd.op = OP_TICK;
			end
			default: begin
				keep     = 1'b0;
				q_cmd.op = OP_TICK;
			end
		endcase
	end

	assign q_push = accept && keep;

endmodule

// ----- rtl/wvm_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short request queue between front and back
module wvm_cmd_fifo import wvm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = 32'(count_q) == QUEUE_DEPTH;
	assign pop_valid = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/wvm_back.sv -----
`timescale 1ns / 1ps
// Back end: applies pitch and on requests, and for a tick walks the voices
// through a four stage pipe (realign, phase/lookup, gain, accumulate), then
// scales by the master gain in two partial products and saturates.
module wvm_back import wvm_pkg::*; #(
	parameter int MAX_VOICES = DEF_MAX_VOICES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	wvm_out_if.source out_ch
);

	localparam int VIX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int N_W    = $clog2(MAX_VOICES + 1);
	localparam int BLK_W  = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;
	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(MAX_VOICES);
	localparam int LO_W   = (ACC_W + 1) / 2;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int TOT_W  = ACC_W + GAIN_W;
	localparam int SH_W   = TOT_W - OUT_SHIFT;

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_WALK   = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_MAG    = 7'b0001000,
		ST_MUL_LO = 7'b0010000,
		ST_MUL_HI = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t state_q;

	// per-voice state
	logic [INC_W-1:0]   pend_q  [MAX_VOICES];
	logic [INC_W-1:0]   step_q  [MAX_VOICES];
	logic [PHASE_W-1:0] phase_q [MAX_VOICES];
	logic               on_q    [MAX_VOICES];

	logic [BLK_W-1:0]   sib_q;
	logic [COUNT_W-1:0] bc_q;
	logic               blk_q;
	logic [N_W-1:0]     n_q;
	logic [VIX_W-1:0]   vi_q;

	// voice pipe
	logic               v_s1;
	logic [VIX_W-1:0]   vi_s1;
	logic [INC_W-1:0]   step_s1;
	logic [PHASE_W-1:0] phase_s1;
	logic [RE_W-1:0]    re_s1;
	logic               take_s1;
	logic               on_s1;
	logic               v_s2;
	logic signed [SAMPLE_W-1:0] rom_s2;
	logic               on_s2;
	logic               v_s3;
	logic signed [PROD_W-1:0]   prod_s3;

	logic signed [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]           mag_q;
	logic                       neg_q;
	logic [LO_W+GAIN_W-1:0]     plo_q;
	logic [HI_W+GAIN_W-1:0]     phi_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       clipped_q;

	logic [N_W-1:0]             n_eff;
	logic [VIX_W-1:0]           cmd_vix;
	logic                       tick_go;
	logic [INC_W-1:0]           cur_pend;
	logic                       take;
	logic [INC_W-1:0]           step_new;
	logic [2*RE_W-1:0]          re_full;
	logic                       last;
	logic [PHASE_W-1:0]         phase_base;
	logic [PHASE_W-1:0]         phase_new;
	logic signed [GAIN_W:0]     mix_s;
	logic signed [PROD_W-1:0]   prod_c;
	logic [TOT_W-1:0]           total;
	logic [SH_W-1:0]            sh;
	logic [SH_W-1:0]            sh_neg;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] sample_c;
	logic                       clip_c;

	// request decode
	assign n_eff   = (32'(cfg.active_voices) > MAX_VOICES) ? N_W'(MAX_VOICES)
	                                                       : N_W'(cfg.active_voices);
	assign cmd_vix = VIX_W'(q_cmd.voice);
	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign tick_go = q_pop && (q_cmd.op == OP_TICK);

	// stage 1: pending step pickup and realign product
	assign cur_pend = pend_q[vi_q];
	assign take     = blk_q && (cur_pend != '0);
	assign step_new = take ? cur_pend : step_q[vi_q];
	assign re_full  = step_new[RE_W-1:0] * bc_q[RE_W-1:0];
	assign last     = (32'(vi_q) + 1) == 32'(n_q);

	// stage 2: phase advance, realigned at a block start
	assign phase_base = take_s1 ? {re_s1, {BLOCK_LOG2{1'b0}}} : phase_s1;
	assign phase_new  = phase_base + step_s1;

	// stage 3: voice gain
	assign mix_s  = $signed({1'b0, cfg.mix_gain});
	assign prod_c = rom_s2 * mix_s;

	// final scale, truncation toward zero and saturation
	assign total  = (TOT_W'(phi_q) << LO_W) + TOT_W'(plo_q);
	assign sh     = total[TOT_W-1:OUT_SHIFT];
	assign sh_neg = '0 - sh;
	always_comb begin
		if (neg_q) begin
			clip_c   = sh > SH_W'(NEG_LIMIT);
			sample_c = clip_c ? SAMPLE_MIN : SAMPLE_W'(sh_neg);
		end else begin
			clip_c   = sh > SH_W'(POS_LIMIT);
			sample_c = clip_c ? SAMPLE_MAX : SAMPLE_W'(sh);
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;

	// sequencer and block counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sib_q   <= '0;
			bc_q    <= '0;
			blk_q   <= 1'b0;
			n_q     <= '0;
			vi_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						if (sib_q == '0) begin
							bc_q <= bc_q + 1'b1;
						end
						blk_q <= sib_q == '0;
						if (32'(sib_q) == BLOCK_LEN - 1) begin
							sib_q <= '0;
						end else begin
							sib_q <= sib_q + 1'b1;
						end
						n_q     <= n_eff;
						vi_q    <= '0;
						state_q <= (n_eff == '0) ? ST_MAG : ST_WALK;
					end
				end
				ST_WALK: begin
					vi_q <= vi_q + 1'b1;
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG:    state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// voice state: pitch/on writes, step takeover, phase writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '{default: '0};
			step_q  <= '{default: '0};
			phase_q <= '{default: '0};
			on_q    <= '{default: 1'b0};
		end else begin
			if (q_pop && (q_cmd.op == OP_PITCH)) begin
				pend_q[cmd_vix] <= q_cmd.increment;
			end
			if (q_pop && (q_cmd.op == OP_ON)) begin
				on_q[cmd_vix] <= q_cmd.on_flag;
			end
			if ((state_q == ST_WALK) && take) begin
				step_q[vi_q] <= cur_pend;
				pend_q[vi_q] <= '0;
			end
			if (v_s1) begin
				phase_q[vi_s1] <= phase_new;
			end
		end
	end

	// pipe valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_WALK;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		vi_s1    <= vi_q;
		step_s1  <= step_new;
		phase_s1 <= phase_q[vi_q];
		re_s1    <= re_full[RE_W-1:0];
		take_s1  <= take;
		on_s1    <= on_q[vi_q];

		rom_s2 <= SINE_ROM[phase_new[PHASE_W-1 -: TABLE_LOG2]];
		on_s2  <= on_s1;

		prod_s3 <= on_s2 ? prod_c : '0;

		if (tick_go) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end

		if (state_q == ST_MAG) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		end
		if (state_q == ST_MUL_LO) begin
			plo_q <= mag_q[LO_W-1:0] * cfg.master_gain;
		end
		if (state_q == ST_MUL_HI) begin
			phi_q <= mag_q[ACC_W-1:LO_W] * cfg.master_gain;
		end
		if ((state_q == ST_FIN) && out_free) begin
			sample_q  <= sample_c;
			clipped_q <= clip_c;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.sample  = sample_q;
	assign out_ch.clipped = clipped_q;

endmodule

// ----- bench/wvm_mixer_checker.sv -----
`timescale 1ns / 1ps
// Watches the request and sample channels of the voice mixer, keeps its own
// copy of the voice state and registers, and compares every sample that
// leaves the block against the predicted one.
module wvm_mixer_checker import wvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wvm_in_if                     in_mon,
	wvm_out_if                    out_mon,
	output int                    fail_count,
	output int                    pending_count
);

	localparam int          MAX_PRINT   = 20;
	localparam int          VOICES      = DEF_MAX_VOICES;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} mix_result_t;

	// Sine table and mirrored voice state
	logic signed [SAMPLE_W-1:0] sine_lut [TABLE_LEN];
	logic [PHASE_W-1:0]         phase_acc [VOICES];
	logic [INC_W-1:0]           step_cur [VOICES];
	logic [INC_W-1:0]           step_pend [VOICES];
	logic                       voice_sounding [VOICES];
	logic [BLOCK_LOG2-1:0]      blk_pos;
	logic [COUNT_W-1:0]         blk_num;
	logic [ACTIVE_W-1:0]        cfg_active;
	logic [GAIN_W-1:0]          cfg_mix;
	logic [GAIN_W-1:0]          cfg_master;

	mix_result_t expected_samples [$];
	int          errors;
	int          samples_seen;

	assign fail_count = errors;

	// One sine period in Q1.15: quarter-wave series in Q30, rounded half up
	function automatic void fill_sine_lut();
		logic [63:0] p;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [1:0]  quad;
		for (int i = 0; i < TABLE_LEN; i++) begin
			p    = 64'(i) << (32 - TABLE_LOG2);
			quad = p[31:30];
			f    = {34'd0, p[29:0]};
			if (quad[0]) begin
				f = Q30_ONE - f;
			end
			x  = (f * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 64'd110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			sine_lut[i] = quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
		end
	endfunction

	initial fill_sine_lut();

	function automatic void clear_voices();
		for (int i = 0; i < VOICES; i++) begin
			phase_acc[i]      = '0;
			step_cur[i]       = '0;
			step_pend[i]      = '0;
			voice_sounding[i] = 1'b0;
		end
		blk_pos    = '0;
		blk_num    = '0;
		cfg_active = ACTIVE_RST;
		cfg_mix    = MIX_RST;
		cfg_master = MASTER_RST;
		expected_samples.delete();
	endfunction

	// One tick: block-start pitch update, phase advance, mix, master gain
	function automatic mix_result_t mix_tick();
		mix_result_t res;
		int          n;
		longint      acc;
		longint      mag;
		logic        neg;
		logic [63:0] prod;
		acc = 0;
		n   = (cfg_active > VOICES) ? VOICES : int'(cfg_active);
		if (blk_pos == '0) begin
			blk_num = blk_num + 1'b1;
			for (int i = 0; i < n; i++) begin
				if (step_pend[i] != '0) begin
					step_cur[i]  = step_pend[i];
					// realign to step * block count * block length, table wrap
					prod         = 64'(step_cur[i]) * 64'(blk_num);
					phase_acc[i] = PHASE_W'(prod << BLOCK_LOG2);
					step_pend[i] = '0;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			phase_acc[i] = phase_acc[i] + PHASE_W'(step_cur[i]);
			if (voice_sounding[i]) begin
				acc += longint'(sine_lut[phase_acc[i][PHASE_W-1 -: TABLE_LOG2]])
					* longint'(cfg_mix);
			end
		end
		// block position wraps at the block length by its width
		blk_pos = blk_pos + 1'b1;

		acc = acc * longint'(cfg_master);
		neg = acc < 0;
		mag = neg ? -acc : acc;
		mag = mag >> OUT_SHIFT;
		res.clipped = 1'b0;
		if (!neg && mag > POS_LIMIT) begin
			res.sample  = SAMPLE_MAX;
			res.clipped = 1'b1;
		end else if (neg && mag > NEG_LIMIT) begin
			res.sample  = SAMPLE_MIN;
			res.clipped = 1'b1;
		end else begin
			res.sample = neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINT) begin
			$display("ERROR @%0t: %s", $time, what);
		end
	endtask

	initial errors = 0;

	// Compare leaving samples first, then apply register writes and requests
	always @(posedge clk or negedge arst_n) begin : watch
		mix_result_t want;
		if (!arst_n) begin
			clear_voices();
			samples_seen  = 0;
			pending_count <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_samples.size() == 0) begin
					flag_mismatch($sformatf("sample %0d arrived with none expected",
						out_mon.sample));
				end else begin
					want = expected_samples.pop_front();
					if (out_mon.sample !== want.sample) begin
						flag_mismatch($sformatf("sample #%0d: got %0d, want %0d",
							samples_seen, out_mon.sample, want.sample));
					end
					if (out_mon.clipped !== want.clipped) begin
						flag_mismatch($sformatf("sample #%0d: clip flag %b, want %b",
							samples_seen, out_mon.clipped, want.clipped));
					end
				end
				samples_seen++;
			end

			if (cfg_we) begin
				case (cfg_idx)
					CFG_ACTIVE: cfg_active = cfg_wdata[ACTIVE_W-1:0];
					CFG_MIX:    cfg_mix    = cfg_wdata[GAIN_W-1:0];
					CFG_MASTER: cfg_master = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end

			if (in_mon.valid && in_mon.ready) begin
				case (in_mon.kind)
					KIND_PITCH: begin
						if (in_mon.increment != '0) begin
							step_pend[in_mon.voice] = in_mon.increment;
						end
					end
					KIND_ON:   voice_sounding[in_mon.voice] = in_mon.on_flag;
					KIND_TICK: expected_samples.push_back(mix_tick());
					default: ;
				endcase
			end
			pending_count <= expected_samples.size();
		end
	end

endmodule

// ----- bench/tb_wavetable_voice_mixer.sv -----
`timescale 1ns / 1ps
// Drives pitch, on-flag and tick requests into the voice mixer through
// several register settings, with random idling on both channels and one
// long output hold-off; the checker beside the block judges every sample.
module tb_wavetable_voice_mixer;
	import wvm_pkg::*;

	localparam logic [KIND_W-1:0]    KIND_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
	localparam int                   SETTLE_CYCLES = 64;
	localparam int                   HOLD_CYCLES   = 400;
	localparam int                   PHASES        = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending_count;

	// Pacing controls: steady is shared by sender and receiver, hold_req drives the receiver
	bit hold_req;
	bit steady;

	wvm_in_if  in_ch ();
	wvm_out_if out_ch ();

	wavetable_voice_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	wvm_mixer_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short idle gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Pitch steps: audio range, a shared pool so voices line up, full range, edge values
	function automatic logic [INC_W-1:0] pick_increment();
		logic [INC_W-1:0] pool [4];
		int               r;
		pool = '{26'h0010000, 26'h0030000, 26'h0012345, 26'h3FFFFFF};
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return INC_W'($urandom_range(1 << 12, 1 << 22));
		end else if (r < 60) begin
			return pool[$urandom_range(0, 3)];
		end else if (r < 85) begin
			return INC_W'($urandom_range(1, (1 << INC_W) - 1));
		end
		pool = '{26'h0000001, 26'h3FFFFFF, 26'h2000000, 26'h1FFFFFF};
		return pool[$urandom_range(0, 3)];
	endfunction

	task automatic send_req(input logic [KIND_W-1:0] kind, input logic [VOICE_W-1:0] voice,
		input logic [INC_W-1:0] inc, input logic on_flag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.kind      <= kind;
		in_ch.voice     <= voice;
		in_ch.increment <= inc;
		in_ch.on_flag   <= on_flag;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every sample, then let queued requests drain
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly ticks with pitch and on-flag changes between; ignored requests
	// do not count toward the budget
	task automatic run_random(input int budget);
		int done;
		int r;
		done = 0;
		while (done < budget) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				send_req(KIND_TICK, VOICE_W'($urandom), INC_W'($urandom), 1'($urandom));
				done++;
			end else if (r < 84) begin
				send_req(KIND_PITCH, VOICE_W'($urandom), pick_increment(), 1'($urandom));
				done++;
			end else if (r < 96) begin
				send_req(KIND_ON, VOICE_W'($urandom), INC_W'($urandom),
					$urandom_range(0, 9) < 7);
				done++;
			end else if (r < 98) begin
				send_req(KIND_PITCH, VOICE_W'($urandom), '0, 1'($urandom));
			end else begin
				send_req(KIND_SPARE, VOICE_W'($urandom), INC_W'($urandom), 1'($urandom));
			end
		end
	endtask

	// Sample receiver: random ready runs, a counted hold-off on request
	initial begin : sample_sink
		int   run;
		logic level;
		run   = 0;
		level = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				level    = 1'b0;
				run      = HOLD_CYCLES;
			end else if (steady) begin
				level = 1'b1;
				run   = 0;
			end else if (run > 0) begin
				run--;
			end else if (level) begin
				level = 1'b0;
				run   = pick_gap();
			end else begin
				level = 1'b1;
				run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 7);
			end
			out_ch.ready <= level;
		end
	end

	initial begin : stimulus
		logic [ACTIVE_W-1:0] act;
		int                  budgets [PHASES];
		budgets = '{80, 40, 40, 80, 80, 80, 80, 80};
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= CFG_ACTIVE;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.kind      <= KIND_PITCH;
		in_ch.voice     <= '0;
		in_ch.increment <= '0;
		in_ch.on_flag   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values
		send_req(KIND_PITCH, 4'd0, 26'h0010000, 1'b0);
		send_req(KIND_PITCH, 4'd15, 26'h3FFFFFF, 1'b1);
		send_req(KIND_PITCH, 4'd3, 26'h0000001, 1'b0);
		// zero step leaves voice 5 alone
		send_req(KIND_PITCH, 4'd5, 26'h0000000, 1'b1);
		send_req(KIND_PITCH, 4'd9, 26'h2AAAAAA, 1'b0);
		send_req(KIND_ON, 4'd0, 26'h3FFFFFF, 1'b1);
		send_req(KIND_ON, 4'd15, 26'h0000000, 1'b1);
		send_req(KIND_ON, 4'd3, 26'h1555555, 1'b1);
		send_req(KIND_ON, 4'd9, 26'h0000000, 1'b1);
		send_req(KIND_ON, 4'd5, 26'h0000000, 1'b1);
		// unused kind gives no sample
		send_req(KIND_SPARE, 4'd15, 26'h3FFFFFF, 1'b1);
		repeat (5) send_req(KIND_TICK, 4'd0, 26'h0000000, 1'b0);
		send_req(KIND_ON, 4'd9, 26'h0000000, 1'b0);
		// mid-block pitch stays pending until the next block start
		send_req(KIND_PITCH, 4'd0, 26'h0100000, 1'b0);
		repeat (3) send_req(KIND_TICK, 4'd15, 26'h3FFFFFF, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					// full gain everywhere: clipping
					write_reg(CFG_ACTIVE, 16'd16);
					write_reg(CFG_MIX, 16'hFFFF);
					write_reg(CFG_MASTER, 16'hFFFF);
				end
				1: begin
					write_reg(CFG_ACTIVE, 16'd1);
					write_reg(CFG_MIX, 16'h0000);
				end
				2: begin
					// upper bits masked off: zero voices mixed
					write_reg(CFG_ACTIVE, 16'hFFE0);
					write_reg(CFG_MIX, 16'd20000);
					write_reg(CFG_MASTER, 16'h0000);
					write_reg(CFG_SPARE, 16'($urandom));
				end
				3: begin
					// count above the voice total is capped
					write_reg(CFG_ACTIVE, 16'hFFFF);
					write_reg(CFG_MIX, 16'd3891);
					write_reg(CFG_MASTER, 16'd40000);
				end
				default: begin
					act = ($urandom_range(0, 9) < 2) ? ACTIVE_W'($urandom_range(17, 31))
						: ACTIVE_W'($urandom_range(1, 16));
					write_reg(CFG_ACTIVE, (16'($urandom) & 16'hFFE0) | 16'(act));
					write_reg(CFG_MIX, 16'($urandom));
					write_reg(CFG_MASTER, 16'($urandom));
				end
			endcase
			steady = (ph == 4);
			if (ph == 3) begin
				hold_req = 1'b1;
			end
			run_random(budgets[ph]);
		end
		steady = 1'b0;
		settle();

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
